[sv/lr_pkg.sv]
// Shared types and constants for the line rasterizer core.
// Coordinate widths, stream bus widths, function codes and the item struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

   localparam int COORD_BITS    = 12;
   localparam int TWICE_BITS    = COORD_BITS + 1;
   localparam int DEC_BITS      = COORD_BITS + 3;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      func;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } lr_item_type;

endpackage

`default_nettype wire

[sv/lr_in_stage.sv]
// Input register of the line rasterizer core.
// Holds one request item until the engine takes it; uses lr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lr_in_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: x_start, y_start, x_end, y_end
   input  wire logic [lr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // fields from bit 0: func
   input  wire logic                             req_tuser,
   input  wire logic                             take,
   output logic                                  item_valid,
   output lr_pkg::lr_item_type                   item
);
   import lr_pkg::*;

   logic        valid_ff, valid_in;
   lr_item_type item_ff, item_in;
   logic        accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in        = valid_ff;
      item_in         = item_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in        = 1'b1;
         item_in.func    = req_tuser;
         item_in.x_start = req_tdata[COORD_BITS-1:0];
         item_in.y_start = req_tdata[2*COORD_BITS-1:COORD_BITS];
         item_in.x_end   = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
         item_in.y_end   = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[sv/lr_engine.sv]
// Line setup and step engine with the result register.
// Keeps the line state, serves start and step items; uses lr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lr_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire lr_pkg::lr_item_type   item,
   output logic                       take,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output lr_pkg::coord_type          pixel_x,
   output lr_pkg::coord_type          pixel_y,
   output logic                       valid_res,
   output logic                       last
);
   import lr_pkg::*;

   // line state
   coord_type                  cur_x_ff, cur_x_in;
   coord_type                  cur_y_ff, cur_y_in;
   logic [DEC_BITS-1:0]        decision_ff, decision_in;
   logic [TWICE_BITS-1:0]      minor_twice_ff, minor_twice_in;
   logic [TWICE_BITS-1:0]      major_twice_ff, major_twice_in;
   coord_type                  steps_left_ff, steps_left_in;
   logic                       minor_dir_neg_ff, minor_dir_neg_in;
   logic                       steep_ff, steep_in;
   logic                       active_ff, active_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   coord_type                  px_ff, px_in;
   coord_type                  py_ff, py_in;
   logic                       vres_ff, vres_in;
   logic                       last_ff, last_in;

   // setup terms
   logic signed [COORD_BITS:0] dx, dy, ndx, ndy, minor_d, nminor;
   coord_type                  adx, ady, amin, major;
   coord_type                  sx, sy, ox, oy;
   logic                       steep_s, swap;

   // step terms
   logic [DEC_BITS-1:0]        dec_add, dec_sub;
   coord_type                  minor_cur, minor_nxt, major_nxt;

   assign take = item_valid && (!out_valid_ff || out_ready);

   always_comb begin
      dx      = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_start});
      dy      = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_start});
      ndx     = -dx;
      ndy     = -dy;
      adx     = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady     = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      steep_s = ady > adx;
      swap    = steep_s ? !(item.y_start < item.y_end) : !(item.x_start < item.x_end);
      sx      = swap ? item.x_end : item.x_start;
      sy      = swap ? item.y_end : item.y_start;
      ox      = swap ? item.x_start : item.x_end;
      oy      = swap ? item.y_start : item.y_end;
      minor_d = steep_s ? ($signed({1'b0, ox}) - $signed({1'b0, sx}))
                        : ($signed({1'b0, oy}) - $signed({1'b0, sy}));
      nminor  = -minor_d;
      amin    = minor_d[COORD_BITS] ? nminor[COORD_BITS-1:0] : minor_d[COORD_BITS-1:0];
      major   = steep_s ? ady : adx;
   end

   always_comb begin
      dec_add   = decision_ff + {2'b00, minor_twice_ff};
      dec_sub   = dec_add - {2'b00, major_twice_ff};
      minor_cur = steep_ff ? cur_x_ff : cur_y_ff;
      minor_nxt = minor_dir_neg_ff ? (minor_cur - 1'b1) : (minor_cur + 1'b1);
      major_nxt = (steep_ff ? cur_y_ff : cur_x_ff) + 1'b1;
   end

   always_comb begin
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      decision_in      = decision_ff;
      minor_twice_in   = minor_twice_ff;
      major_twice_in   = major_twice_ff;
      steps_left_in    = steps_left_ff;
      minor_dir_neg_in = minor_dir_neg_ff;
      steep_in         = steep_ff;
      active_in        = active_ff;
      out_valid_in     = out_valid_ff;
      px_in            = px_ff;
      py_in            = py_ff;
      vres_in          = vres_ff;
      last_in          = last_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
         if (item.func == FUNC_START) begin
            cur_x_in         = sx;
            cur_y_in         = sy;
            steep_in         = steep_s;
            minor_dir_neg_in = minor_d[COORD_BITS];
            minor_twice_in   = {amin, 1'b0};
            major_twice_in   = {major, 1'b0};
            decision_in      = {2'b00, amin, 1'b0} - {3'b000, major};
            steps_left_in    = major;
            active_in        = (major != '0);
            px_in            = sx;
            py_in            = sy;
            vres_in          = 1'b1;
            last_in          = (major == '0);
         end else if (!active_ff) begin
            px_in   = '0;
            py_in   = '0;
            vres_in = 1'b0;
            last_in = 1'b0;
         end else begin
            if (decision_ff[DEC_BITS-1]) begin
               decision_in = dec_add;
            end else begin
               decision_in = dec_sub;
               if (steep_ff) begin
                  cur_x_in = minor_nxt;
               end else begin
                  cur_y_in = minor_nxt;
               end
            end
            if (steep_ff) begin
               cur_y_in = major_nxt;
            end else begin
               cur_x_in = major_nxt;
            end
            steps_left_in = steps_left_ff - 1'b1;
            active_in     = (steps_left_ff != {{(COORD_BITS-1){1'b0}}, 1'b1});
            px_in         = cur_x_in;
            py_in         = cur_y_in;
            vres_in       = 1'b1;
            last_in       = !active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff         <= '0;
         cur_y_ff         <= '0;
         decision_ff      <= '0;
         minor_twice_ff   <= '0;
         major_twice_ff   <= '0;
         steps_left_ff    <= '0;
         minor_dir_neg_ff <= 1'b0;
         steep_ff         <= 1'b0;
         active_ff        <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         decision_ff      <= decision_in;
         minor_twice_ff   <= minor_twice_in;
         major_twice_ff   <= major_twice_in;
         steps_left_ff    <= steps_left_in;
         minor_dir_neg_ff <= minor_dir_neg_in;
         steep_ff         <= steep_in;
         active_ff        <= active_in;
         out_valid_ff     <= out_valid_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      vres_ff <= vres_in;
      last_ff <= last_in;
   end

   assign out_valid = out_valid_ff;
   assign pixel_x   = px_ff;
   assign pixel_y   = py_ff;
   assign valid_res = vres_ff;
   assign last      = last_ff;

   a_active_has_steps : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_left_ff != '0))
      else $error("line active with no steps left");

   a_last_is_pixel : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && last_ff) |-> vres_ff)
      else $error("last flag on an invalid result");

   a_take_fills_out : assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("taken item left no result");

   a_last_ends_line : assert property (@(posedge clock) disable iff (reset)
      (take && item.func == FUNC_STEP && active_ff
       && steps_left_ff == {{(COORD_BITS-1){1'b0}}, 1'b1}) |=> (!active_ff && last_ff))
      else $error("final step did not end the line");

endmodule

`default_nettype wire

[sv/line_rasterizer_core.sv]
// Line rasterizer core: Bresenham line walk over all octants on stream buses.
// An accepted request item passes the input register, then the result register.
// Throughput: one item per cycle while rsp_tready is high; setup and each step are one
// pass of add/compare logic between the input register and the result register.
// Reset: synchronous, active high; clears the line state, no line active.
// Depends on lr_pkg, lr_in_stage and lr_engine.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: x_start, y_start, x_end, y_end
   input  wire logic [lr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // fields from bit 0: func
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // fields from bit 0: pixel_x, pixel_y
   output logic [lr_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // fields from bit 0: valid_res
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import lr_pkg::*;

   logic        item_valid, take;
   lr_item_type item;
   coord_type   pixel_x, pixel_y;

   lr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   lr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .valid_res  (rsp_tuser),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({pixel_y, pixel_x});

endmodule

`default_nettype wire
